FILE: rtl/assert_macros.svh
// assertion helper macros for the priority queue checker
// no dependencies; expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/mhpq_pkg.sv
// shared types and codes for the max-heap priority queue
// no dependencies; used by the level cells, the top level and the checker
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int VAL_W   = 32;
  localparam int OCC_W   = 9;
  localparam int POS_W   = 17;
  localparam int DEPTH_W = 5;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_TOP  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_INSERT,
    CTL_FETCH,
    CTL_SIFT
  } ctl_state_t;

  typedef enum logic [1:0] {
    TK_INSERT,
    TK_FETCH,
    TK_SIFT
  } tok_kind_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [VAL_W-1:0] push_value;
  } heap_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [1:0]              status;
    logic [OCC_W-1:0]        occupancy;
  } heap_rsp_t;

  // token walking down the levels
  typedef struct packed {
    logic                    valid;
    tok_kind_t               kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        path;
    logic [DEPTH_W-1:0]      depth;
    logic [POS_W-1:0]        pos;
    logic [POS_W-1:0]        count;
  } heap_tok_t;

  // write of a promoted child into the level above
  typedef struct packed {
    logic                    we;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } heap_bwd_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] value;
  } lvl_done_t;

endpackage

FILE: rtl/mhpq_level_cell.sv
// one tree level of the heap: two lane memories (left and right children)
// plus a two-stage read/compare step; depends on mhpq_pkg
`timescale 1ns / 1ps

module mhpq_level_cell #(
  parameter int LEVEL  = 1,
  parameter int LEVELS = 2,
  parameter int ROWS   = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  mhpq_pkg::heap_tok_t tok_in,
  output mhpq_pkg::heap_tok_t tok_out,
  input  mhpq_pkg::heap_bwd_t bwd_in,
  output mhpq_pkg::heap_bwd_t bwd_out,
  output mhpq_pkg::lvl_done_t lvl_done
);
  import mhpq_pkg::*;

  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PATH_SH = LEVELS - 1 - LEVEL;
  localparam logic [POS_W-1:0] PMASK = POS_W'((1 << (LEVEL - 1)) - 1);

  logic signed [VAL_W-1:0] mem_l [ROWS];
  logic signed [VAL_W-1:0] mem_r [ROWS];
  logic signed [VAL_W-1:0] rd_l, rd_r;

  heap_tok_t        hold, tok_next;
  logic [AW-1:0]    hold_row, row_in, bwd_row, wr_row;
  logic [POS_W-1:0] q_in, parent_in, q;

  logic                    at_depth, right_ok, pick, grand_ok;
  logic [POS_W:0]          lpos, rpos, cpos;
  logic signed [VAL_W-1:0] v, cur, best;
  logic                    own_we, own_lane, wr_l, wr_r;
  logic signed [VAL_W-1:0] own_val, wr_val;

  // read side: row of the incoming token
  always_comb begin
    q_in      = tok_in.path >> PATH_SH;
    parent_in = (tok_in.kind == TK_SIFT) ? tok_in.pos : (q_in >> 1);
    row_in    = AW'(parent_in & PMASK);
    bwd_row   = AW'((bwd_in.pos >> 1) & PMASK);
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      rd_l     <= mem_l[row_in];
      rd_r     <= mem_r[row_in];
      hold_row <= row_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold    <= '0;
      tok_out <= '0;
    end else begin
      hold    <= tok_in;
      tok_out <= tok_next;
    end
  end

  // compare step
  always_comb begin
    v        = hold.value;
    q        = hold.path >> PATH_SH;
    cur      = q[0] ? rd_r : rd_l;
    at_depth = (hold.depth == DEPTH_W'(LEVEL));
    lpos     = {hold.pos, 1'b0};
    rpos     = {hold.pos, 1'b1};
    right_ok = (rpos <= {1'b0, hold.count});
    pick     = right_ok && (rd_r > rd_l);
    best     = pick ? rd_r : rd_l;
    cpos     = pick ? rpos : lpos;
    grand_ok = ({cpos, 1'b0} <= {2'b00, hold.count});

    own_we   = 1'b0;
    own_lane = 1'b0;
    own_val  = v;
    tok_next = hold;
    tok_next.valid = 1'b0;
    bwd_out  = '0;
    lvl_done = '0;

    if (hold.valid) begin
      unique case (hold.kind)
        TK_INSERT: begin
          if (at_depth) begin
            own_we        = 1'b1;
            own_lane      = q[0];
            lvl_done.done = 1'b1;
          end else begin
            tok_next.valid = 1'b1;
            if (v > cur) begin
              own_we         = 1'b1;
              own_lane       = q[0];
              tok_next.value = cur;
            end
          end
        end
        TK_FETCH: begin
          if (at_depth) begin
            lvl_done.done  = 1'b1;
            lvl_done.value = cur;
          end else begin
            tok_next.valid = 1'b1;
          end
        end
        TK_SIFT: begin
          if (best > v) begin
            own_we        = 1'b1;
            own_lane      = pick;
            bwd_out.we    = 1'b1;
            bwd_out.pos   = hold.pos;
            bwd_out.value = best;
            if (grand_ok) begin
              tok_next.valid = 1'b1;
              tok_next.pos   = cpos[POS_W-1:0];
            end else begin
              lvl_done.done = 1'b1;
            end
          end else begin
            lvl_done.done = 1'b1;
          end
        end
        default: begin
          lvl_done.done = 1'b1;
        end
      endcase
    end
  end

  // write side: own step or promotion from the level below
  always_comb begin
    wr_row = bwd_in.we ? bwd_row : hold_row;
    wr_val = bwd_in.we ? bwd_in.value : own_val;
    wr_l   = (bwd_in.we && !bwd_in.pos[0]) || (own_we && !own_lane);
    wr_r   = (bwd_in.we && bwd_in.pos[0]) || (own_we && own_lane);
  end

  always_ff @(posedge clk) begin
    if (wr_l) begin
      mem_l[wr_row] <= wr_val;
    end
    if (wr_r) begin
      mem_r[wr_row] <= wr_val;
    end
  end

endmodule

FILE: rtl/max_heap_priority_queue.sv
// top level of the max-heap priority queue: controller, root register
// and the chain of level cells; depends on mhpq_pkg and mhpq_level_cell
`timescale 1ns / 1ps

// Bounded max-heap of signed 32-bit values. An item is taken when start is
// high and busy is low; its one result shows on result for exactly one cycle
// with result_valid high and busy is already low in that cycle. Reads, unused
// codes, pushes into an empty queue, pushes on a full queue, pops of an empty
// or one-entry queue return in the cycle after the item is taken. A push into a
// non-empty queue walks one level cell per tree level down to the new slot
// (registered row read, then compare and write in each cell). A pop first
// walks down to fetch the last entry, then, if more than one entry remains,
// sifts it down from the root through the same cells; at 256 entries the
// fetch goes through eight levels and the sift through seven.

module max_heap_priority_queue #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  mhpq_pkg::heap_req_t request,
  output logic                result_valid,
  output mhpq_pkg::heap_rsp_t result
);
  import mhpq_pkg::*;

  localparam int LEVELS = $clog2(CAPACITY + 1);
  localparam int CW     = $clog2(CAPACITY + 1);

  function automatic logic [DEPTH_W-1:0] floor_log2(input logic [POS_W-1:0] t);
    logic [DEPTH_W-1:0] d;
    d = '0;
    for (int b = 0; b < POS_W; b++) begin
      if (t[b]) begin
        d = DEPTH_W'(b);
      end
    end
    return d;
  endfunction

  ctl_state_t              state, state_next;
  logic [CW-1:0]           count, count_next;
  logic signed [VAL_W-1:0] root, root_next;
  heap_rsp_t               pending, pending_next, result_next;
  logic                    result_valid_next;
  heap_tok_t               launch, launch_next;

  heap_tok_t tok [1:LEVELS];
  heap_bwd_t bwd [1:LEVELS];
  lvl_done_t lvl [1:LEVELS-1];

  logic                    done_any;
  logic signed [VAL_W-1:0] fetch_val;
  logic [POS_W-1:0]        cnt_pos, tgt, tgt_path;
  logic [DEPTH_W-1:0]      tgt_depth;

  assign tok[1]      = launch;
  assign bwd[LEVELS] = '0;
  assign busy        = (state != CTL_IDLE);

  for (genvar g = 1; g < LEVELS; g++) begin : g_level
    localparam int Base = (1 << g) - 1;
    localparam int Half = (CAPACITY - Base + 1) / 2;
    localparam int Rows = (Half < (1 << (g - 1))) ? Half : (1 << (g - 1));

    mhpq_level_cell #(
      .LEVEL (g),
      .LEVELS(LEVELS),
      .ROWS  (Rows)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1]),
      .bwd_in  (bwd[g+1]),
      .bwd_out (bwd[g]),
      .lvl_done(lvl[g])
    );
  end

  always_comb begin
    done_any  = tok[LEVELS].valid;
    fetch_val = '0;
    for (int g = 1; g < LEVELS; g++) begin
      done_any  = done_any | lvl[g].done;
      fetch_val = fetch_val | lvl[g].value;
    end
  end

  // target slot of a push (next free) or a pop (last used), 1-based
  always_comb begin
    cnt_pos   = POS_W'(count);
    tgt       = (request.operation == OP_POP) ? cnt_pos : cnt_pos + POS_W'(1);
    tgt_depth = floor_log2(tgt);
    tgt_path  = tgt << (DEPTH_W'(LEVELS - 1) - tgt_depth);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CTL_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      launch       <= '0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= result_valid_next;
      launch       <= launch_next;
    end
  end

  always_ff @(posedge clk) begin
    root    <= root_next;
    pending <= pending_next;
    result  <= result_next;
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    root_next         = root;
    pending_next      = pending;
    result_next       = result;
    result_valid_next = 1'b0;
    launch_next       = '0;

    if (bwd[1].we) begin
      root_next = bwd[1].value;
    end

    unique case (state)
      CTL_IDLE: begin
        if (start) begin
          result_valid_next = 1'b1;
          unique case (request.operation)
            OP_PUSH: begin
              if (count == CW'(CAPACITY)) begin
                result_next = '{result_value: '0, status: ST_FULL,
                                occupancy: OCC_W'(count)};
              end else if (count == '0) begin
                root_next   = request.push_value;
                count_next  = CW'(1);
                result_next = '{result_value: '0, status: ST_OK,
                                occupancy: OCC_W'(1)};
              end else begin
                result_valid_next = 1'b0;
                count_next        = count + CW'(1);
                pending_next      = '{result_value: '0, status: ST_OK,
                                      occupancy: OCC_W'(count + CW'(1))};
                launch_next.valid = 1'b1;
                launch_next.kind  = TK_INSERT;
                launch_next.path  = tgt_path;
                launch_next.depth = tgt_depth;
                if (request.push_value > root) begin
                  root_next         = request.push_value;
                  launch_next.value = root;
                end else begin
                  launch_next.value = request.push_value;
                end
                state_next = CTL_INSERT;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                result_next = '{result_value: '0, status: ST_EMPTY,
                                occupancy: OCC_W'(count)};
              end else if (count == CW'(1)) begin
                count_next  = '0;
                result_next = '{result_value: root, status: ST_OK,
                                occupancy: OCC_W'(0)};
              end else begin
                result_valid_next = 1'b0;
                count_next        = count - CW'(1);
                pending_next      = '{result_value: root, status: ST_OK,
                                      occupancy: OCC_W'(count - CW'(1))};
                launch_next.valid = 1'b1;
                launch_next.kind  = TK_FETCH;
                launch_next.path  = tgt_path;
                launch_next.depth = tgt_depth;
                state_next        = CTL_FETCH;
              end
            end
            OP_TOP: begin
              if (count == '0) begin
                result_next = '{result_value: '0, status: ST_EMPTY,
                                occupancy: OCC_W'(count)};
              end else begin
                result_next = '{result_value: root, status: ST_OK,
                                occupancy: OCC_W'(count)};
              end
            end
            default: begin
              result_next = '{result_value: '0, status: ST_OK,
                              occupancy: OCC_W'(count)};
            end
          endcase
        end
      end
      CTL_INSERT: begin
        if (done_any) begin
          result_valid_next = 1'b1;
          result_next       = pending;
          state_next        = CTL_IDLE;
        end
      end
      CTL_FETCH: begin
        if (done_any) begin
          root_next = fetch_val;
          if (count >= CW'(2)) begin
            launch_next.valid = 1'b1;
            launch_next.kind  = TK_SIFT;
            launch_next.value = fetch_val;
            launch_next.pos   = POS_W'(1);
            launch_next.count = cnt_pos;
            state_next        = CTL_SIFT;
          end else begin
            result_valid_next = 1'b1;
            result_next       = pending;
            state_next        = CTL_IDLE;
          end
        end
      end
      CTL_SIFT: begin
        if (done_any) begin
          result_valid_next = 1'b1;
          result_next       = pending;
          state_next        = CTL_IDLE;
        end
      end
    endcase
  end

endmodule

FILE: rtl/mhpq_checker.sv
// port-level checks for the max-heap priority queue and their bind
// depends on mhpq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mhpq_checker #(
  parameter int CAPACITY = 256
) (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input mhpq_pkg::heap_req_t request,
  input logic                result_valid,
  input mhpq_pkg::heap_rsp_t result
);
  import mhpq_pkg::*;

  `ASSERT_NEXT(a_top_next, start && !busy && request.operation == OP_TOP, result_valid)
  `ASSERT_NEXT(a_accept_moves, start && !busy, busy || result_valid)
  `ASSERT_IMPLIES(a_result_idle, result_valid, !busy)
  `ASSERT_IMPLIES(a_full_occ, result_valid && result.status == ST_FULL, result.occupancy == OCC_W'(CAPACITY) && result.result_value == '0)
  `ASSERT_IMPLIES(a_empty_zero, result_valid && result.status == ST_EMPTY, result.occupancy == '0 && result.result_value == '0)

endmodule

bind max_heap_priority_queue mhpq_checker #(.CAPACITY(CAPACITY)) u_mhpq_checker (.*);

FILE: sim/max_heap_priority_queue_check.sv
// checker for the max-heap priority queue: watches the request and result channels,
// keeps its own heap to predict each result and compares field by field
// depends on mhpq_pkg
`timescale 1ns / 1ps

module max_heap_priority_queue_check #(
  parameter int CAPACITY = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  mhpq_pkg::heap_req_t request,
  input  logic                result_valid,
  input  mhpq_pkg::heap_rsp_t result,
  output int                  errors,
  output int                  pending
);
  import mhpq_pkg::*;

  logic signed [VAL_W-1:0] heap_slots [CAPACITY];
  int unsigned heap_len;
  heap_rsp_t expected_rsp_q [$];

  function automatic void swap_slots(input int unsigned a, input int unsigned b);
    logic signed [VAL_W-1:0] tmp;
    tmp = heap_slots[a];
    heap_slots[a] = heap_slots[b];
    heap_slots[b] = tmp;
  endfunction

  function automatic heap_rsp_t apply_heap_op(input heap_req_t item);
    heap_rsp_t rsp;
    int unsigned pos, parent, child, best;
    bit done;
    rsp = '0;
    case (item.operation)
      OP_PUSH: begin
        if (heap_len >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          pos = heap_len;
          heap_slots[pos] = item.push_value;
          heap_len++;
          done = 1'b0;
          while (pos > 0 && !done) begin
            parent = (pos - 1) / 2;
            if (heap_slots[pos] > heap_slots[parent]) begin
              swap_slots(pos, parent);
              pos = parent;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
      OP_POP: begin
        if (heap_len == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.result_value = heap_slots[0];
          heap_len--;
          heap_slots[0] = heap_slots[heap_len];
          pos = 0;
          done = 1'b0;
          while (!done) begin
            best = pos;
            child = pos * 2 + 1;
            // left child wins a tie between children
            if (child < heap_len && heap_slots[child] > heap_slots[best]) best = child;
            if (child + 1 < heap_len && heap_slots[child + 1] > heap_slots[best])
              best = child + 1;
            if (best == pos) begin
              done = 1'b1;
            end else begin
              swap_slots(pos, best);
              pos = best;
            end
          end
        end
      end
      OP_TOP: begin
        if (heap_len == 0) rsp.status = ST_EMPTY;
        else rsp.result_value = heap_slots[0];
      end
      default: ;
    endcase
    rsp.occupancy = OCC_W'(heap_len);
    return rsp;
  endfunction

  always @(posedge clk) begin
    heap_rsp_t want;
    if (rst) begin
      heap_len = 0;
      expected_rsp_q.delete();
    end else begin
      // results first: a new item taken at this edge can only cause a later one
      if (result_valid) begin
        if (expected_rsp_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: value %0d status %0d occupancy %0d",
                     result.result_value, result.status, result.occupancy);
        end else begin
          want = expected_rsp_q.pop_front();
          if (result.result_value !== want.result_value || result.status !== want.status ||
              result.occupancy !== want.occupancy) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected value %0d status %0d occupancy %0d, got value %0d status %0d occupancy %0d",
                       want.result_value, want.status, want.occupancy,
                       result.result_value, result.status, result.occupancy);
          end
        end
      end
      if (start && !busy) expected_rsp_q.push_back(apply_heap_op(request));
    end
    pending = expected_rsp_q.size();
  end

endmodule

FILE: sim/max_heap_priority_queue_tb.sv
// testbench top for the max-heap priority queue: clock, reset, directed and random items
// depends on mhpq_pkg, max_heap_priority_queue and max_heap_priority_queue_check
`timescale 1ns / 1ps

module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int CAPACITY = 256;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  heap_req_t request;
  logic      result_valid;
  heap_rsp_t result;
  int        errors;
  int        pending;

  max_heap_priority_queue #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result)
  );

  max_heap_priority_queue_check #(.CAPACITY(CAPACITY)) checker_inst (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result),
    .errors(errors),
    .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'sh7fffffff;
      1: v = 32'sh80000000;
      2, 3: v = $urandom_range(0, 7) - 4;  // narrow range for ties
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic heap_req_t make_item(input int unsigned push_pct);
    heap_req_t item;
    int unsigned r;
    item.push_value = pick_value();
    if ($urandom_range(0, 99) < push_pct) begin
      item.operation = OP_PUSH;
    end else begin
      r = $urandom_range(0, 19);
      if (r == 0) item.operation = OP_UNUSED;
      else if (r < 4) item.operation = OP_TOP;
      else item.operation = OP_POP;
    end
    return item;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic issue(input heap_req_t item, input int unsigned gap);
    start <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      request <= '{operation: 2'($urandom()), push_value: $urandom()};
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic issue_op(input logic [1:0] op, input logic signed [VAL_W-1:0] v);
    heap_req_t item;
    item.operation = op;
    item.push_value = v;
    issue(item, pick_gap());
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned push_pct,
                           input bit idle);
    for (int unsigned k = 0; k < n; k++)
      issue(make_item(push_pct), idle ? pick_gap() : 0);
  endtask

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int waited;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue
    issue_op(OP_TOP, 32'sd77);
    issue_op(OP_POP, -32'sd5);
    issue_op(OP_UNUSED, 32'sh7fffffff);
    // extremes and ties
    issue_op(OP_PUSH, 32'sh7fffffff);
    issue_op(OP_PUSH, 32'sh80000000);
    issue_op(OP_PUSH, 32'sd0);
    issue_op(OP_PUSH, -32'sd1);
    issue_op(OP_PUSH, 32'sd1);
    issue_op(OP_PUSH, 32'sd5);
    issue_op(OP_PUSH, 32'sd5);
    issue_op(OP_PUSH, 32'sd5);
    issue_op(OP_TOP, 32'sh80000000);
    issue_op(OP_UNUSED, -32'sd1);
    for (int k = 0; k < 9; k++) issue_op(OP_POP, $urandom());

    // fill to full, drain to empty, mixed, again
    run_phase(330, 92, 1'b1);
    run_phase(400, 5, 1'b0);
    run_phase(250, 50, 1'b1);
    run_phase(330, 90, 1'b0);
    run_phase(190, 5, 1'b1);

    start <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: max_heap_priority_queue.f
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_level_cell.sv
rtl/max_heap_priority_queue.sv
rtl/mhpq_checker.sv
sim/max_heap_priority_queue_check.sv
sim/max_heap_priority_queue_tb.sv
